>>> src/hvp_pkg.sv
package hvp_pkg;

  localparam int TRIG_W = 16;
  localparam int POS_W = 20;
  localparam int OUT_W = 20;
  localparam int IDX_W = 14;
  localparam int DIM_W = 5;
  localparam int CFG_W = 16;

  typedef logic signed [TRIG_W-1:0] trig_t;
  typedef logic signed [POS_W-1:0] pos_t;

  typedef struct packed {
    trig_t cos_yaw;
    trig_t sin_yaw;
    trig_t cos_pitch;
    trig_t sin_pitch;
  } view_trig_t;

  typedef enum logic [2:0] {
    TRIG_IDLE,
    TRIG_SETUP,
    TRIG_SQUARE,
    TRIG_HORNER,
    TRIG_FINAL
  } trig_state_t;

  localparam logic [2:0] REG_DIMENSION_COUNT = 3'd0;
  localparam logic [2:0] REG_FOLD_PHASE      = 3'd1;
  localparam logic [2:0] REG_CAMERA_POS_X    = 3'd2;
  localparam logic [2:0] REG_CAMERA_POS_Y    = 3'd3;
  localparam logic [2:0] REG_CAMERA_POS_Z    = 3'd4;
  localparam logic [2:0] REG_YAW_PHASE       = 3'd5;
  localparam logic [2:0] REG_PITCH_PHASE     = 3'd6;

  localparam logic [31:0] K1 = 32'd1686629713;
  localparam logic [31:0] K3 = 32'd693598669;
  localparam logic [31:0] K5 = 32'd85569306;
  localparam logic [31:0] K7 = 32'd5026995;
  localparam logic [31:0] K9 = 32'd172272;

  localparam logic [15:0] QUARTER_TURN = 16'h4000;
  localparam logic [14:0] QUARTER_ONE = 15'd16384;

  localparam int VIEW_DIST_Q8 = 1280;
  localparam int FOCAL_Q4 = 12800;

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // half a radian step per dimension, in phase units
  function automatic logic [15:0] fold_offset(input int i);
    logic [63:0] t;
    t = 64'(i) * 64'd341782637 + 64'd32768;
    return t[31:16];
  endfunction

  function automatic logic [31:0] horner_coef(input logic [1:0] step);
    logic [31:0] k;
    unique case (step)
      2'd0: k = K7;
      2'd1: k = K5;
      2'd2: k = K3;
      default: k = K1;
    endcase
    return k;
  endfunction

endpackage

>>> src/hvp_trig.sv
module hvp_trig import hvp_pkg::*; #(
  parameter int MAX_DIMENSION = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] fold_phase,
  input  logic [15:0] yaw_phase,
  input  logic [15:0] pitch_phase16,
  output logic        busy,
  output trig_t       cos_tab [MAX_DIMENSION],
  output trig_t       sin_tab [MAX_DIMENSION],
  output view_trig_t  view_trig
);

  localparam int NANG = 2 * MAX_DIMENSION + 4;
  localparam int K_W = $clog2(NANG);
  localparam logic [K_W-1:0] K_LAST = K_W'(NANG - 1);

  trig_state_t state_r, state_nxt;
  logic [K_W-1:0] k_r, k_nxt;
  logic [1:0] step_r, step_nxt;
  logic [30:0] x_r;
  logic [30:0] x2_r;
  logic [31:0] p_r;
  logic neg_r;
  trig_t cos_tab_r [MAX_DIMENSION];
  trig_t sin_tab_r [MAX_DIMENSION];
  view_trig_t view_r;

  logic [15:0] base_phase;
  logic [15:0] phase;
  logic [14:0] qq;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [33:0] rsum;
  logic [14:0] mag;
  trig_t value;

  always_comb begin
    base_phase = pitch_phase16;
    if (k_r < K_W'(2 * MAX_DIMENSION)) begin
      base_phase = fold_phase;
      for (int i = 0; i < MAX_DIMENSION; i++) begin
        if (k_r[K_W-1:1] == (K_W-1)'(i)) begin
          base_phase = fold_phase + fold_offset(i);
        end
      end
    end else if (k_r < K_W'(2 * MAX_DIMENSION + 2)) begin
      base_phase = yaw_phase;
    end
    phase = base_phase + (k_r[0] ? QUARTER_TURN : 16'd0);
    qq = phase[14] ? (QUARTER_ONE - {1'b0, phase[13:0]}) : {1'b0, phase[13:0]};
  end

  always_comb begin
    unique case (state_r)
      TRIG_SQUARE: begin
        mul_a = {1'b0, x_r};
        mul_b = {1'b0, x_r};
      end
      TRIG_HORNER: begin
        mul_a = p_r;
        mul_b = {1'b0, x2_r};
      end
      TRIG_FINAL: begin
        mul_a = p_r;
        mul_b = {1'b0, x_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = 64'(mul_a) * 64'(mul_b);
    rsum = prod[63:30] + 34'd32768;
    mag = (rsum[33:16] > 18'(QUARTER_ONE)) ? QUARTER_ONE : rsum[30:16];
    value = neg_r ? -trig_t'({1'b0, mag}) : trig_t'({1'b0, mag});
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    if (start) begin
      state_nxt = TRIG_SETUP;
    end else begin
      unique case (state_r)
        TRIG_IDLE:   state_nxt = TRIG_IDLE;
        TRIG_SETUP:  state_nxt = TRIG_SQUARE;
        TRIG_SQUARE: state_nxt = TRIG_HORNER;
        TRIG_HORNER: state_nxt = (step_r == 2'd3) ? TRIG_FINAL : TRIG_HORNER;
        TRIG_FINAL:  state_nxt = (k_r == K_LAST) ? TRIG_IDLE : TRIG_SETUP;
        default:     state_nxt = TRIG_IDLE;
      endcase
    end
  end

  // outputs and counters
  always_comb begin
    busy = (state_r != TRIG_IDLE);
    k_nxt = k_r;
    step_nxt = step_r;
    if (start) begin
      k_nxt = '0;
    end else if (state_r == TRIG_FINAL && k_r != K_LAST) begin
      k_nxt = k_r + 1'b1;
    end
    if (state_r == TRIG_SQUARE) begin
      step_nxt = '0;
    end else if (state_r == TRIG_HORNER) begin
      step_nxt = step_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= TRIG_SETUP;
      k_r <= '0;
      step_r <= '0;
    end else begin
      state_r <= state_nxt;
      k_r <= k_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      TRIG_SETUP: begin
        x_r <= {qq, 16'd0};
        neg_r <= phase[15];
      end
      TRIG_SQUARE: begin
        x2_r <= prod[60:30];
        p_r <= K9;
      end
      TRIG_HORNER: begin
        p_r <= horner_coef(step_r) - prod[61:30];
      end
      TRIG_FINAL: begin
        for (int i = 0; i < MAX_DIMENSION; i++) begin
          if (k_r == K_W'(2 * i)) sin_tab_r[i] <= value;
          if (k_r == K_W'(2 * i + 1)) cos_tab_r[i] <= value;
        end
        if (k_r == K_W'(2 * MAX_DIMENSION)) view_r.sin_yaw <= value;
        if (k_r == K_W'(2 * MAX_DIMENSION + 1)) view_r.cos_yaw <= value;
        if (k_r == K_W'(2 * MAX_DIMENSION + 2)) view_r.sin_pitch <= value;
        if (k_r == K_W'(2 * MAX_DIMENSION + 3)) view_r.cos_pitch <= value;
      end
      default: begin
      end
    endcase
  end

  assign cos_tab = cos_tab_r;
  assign sin_tab = sin_tab_r;
  assign view_trig = view_r;

endmodule

>>> src/hvp_fold.sv
module hvp_fold import hvp_pkg::*; #(
  parameter int MAX_DIMENSION = 14
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [IDX_W-1:0]   in_index,
  input  logic [DIM_W-1:0]   dims,
  input  trig_t              cos_tab [MAX_DIMENSION],
  input  trig_t              sin_tab [MAX_DIMENSION],
  input  logic signed [15:0] cam_x,
  input  logic signed [15:0] cam_y,
  input  logic signed [15:0] cam_z,
  output logic               out_valid,
  output pos_t               dx,
  output pos_t               dy,
  output pos_t               dz
);

  localparam int SUM_W = TRIG_W + $clog2(MAX_DIMENSION);
  localparam int NGRP = (MAX_DIMENSION + 3) / 4;

  typedef logic signed [SUM_W-1:0] sum_t;

  localparam sum_t HALF_Q6 = sum_t'(32);

  logic [MAX_DIMENSION-1:0] idx_ext;
  sum_t gx_nxt [NGRP], gy_nxt [NGRP], gz_nxt [NGRP];
  sum_t gx_r [NGRP], gy_r [NGRP], gz_r [NGRP];
  sum_t sx_nxt, sy_nxt, sz_nxt;
  sum_t sx_r, sy_r, sz_r;
  pos_t dx_nxt, dy_nxt, dz_nxt;
  pos_t dx_r, dy_r, dz_r;
  logic v1_r, v2_r, v3_r;

  assign idx_ext = MAX_DIMENSION'(in_index);

  // partial sums of four dimensions each
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      gx_nxt[g] = '0;
      gy_nxt[g] = '0;
      gz_nxt[g] = '0;
      for (int j = 0; j < 4; j++) begin
        if (g * 4 + j < MAX_DIMENSION && g * 4 + j < int'(dims)) begin
          if (idx_ext[g*4+j]) begin
            gx_nxt[g] = gx_nxt[g] + SUM_W'(cos_tab[g*4+j]);
            gy_nxt[g] = gy_nxt[g] + SUM_W'(sin_tab[g*4+j]);
            if ((g * 4 + j) % 2 == 0) gz_nxt[g] = gz_nxt[g] + SUM_W'(cos_tab[g*4+j]);
            else gz_nxt[g] = gz_nxt[g] + SUM_W'(sin_tab[g*4+j]);
          end else begin
            gx_nxt[g] = gx_nxt[g] - SUM_W'(cos_tab[g*4+j]);
            gy_nxt[g] = gy_nxt[g] - SUM_W'(sin_tab[g*4+j]);
            if ((g * 4 + j) % 2 == 0) gz_nxt[g] = gz_nxt[g] - SUM_W'(cos_tab[g*4+j]);
            else gz_nxt[g] = gz_nxt[g] - SUM_W'(sin_tab[g*4+j]);
          end
        end
      end
    end
  end

  always_comb begin
    sx_nxt = '0;
    sy_nxt = '0;
    sz_nxt = '0;
    for (int g = 0; g < NGRP; g++) begin
      sx_nxt = sx_nxt + gx_r[g];
      sy_nxt = sy_nxt + gy_r[g];
      sz_nxt = sz_nxt + gz_r[g];
    end
  end

  // Q1.14 to Q8.8 with rounding, then camera offset
  always_comb begin
    dx_nxt = POS_W'((sx_r + HALF_Q6) >>> 6) - POS_W'(cam_x);
    dy_nxt = POS_W'((sy_r + HALF_Q6) >>> 6) - POS_W'(cam_y);
    dz_nxt = POS_W'((sz_r + HALF_Q6) >>> 6) - POS_W'(cam_z);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gx_r <= gx_nxt;
      gy_r <= gy_nxt;
      gz_r <= gz_nxt;
      sx_r <= sx_nxt;
      sy_r <= sy_nxt;
      sz_r <= sz_nxt;
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
      dz_r <= dz_nxt;
    end
  end

  assign out_valid = v3_r;
  assign dx = dx_r;
  assign dy = dy_r;
  assign dz = dz_r;

endmodule

>>> src/hvp_rotate.sv
module hvp_rotate import hvp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       en,
  input  logic       in_valid,
  input  pos_t       dx,
  input  pos_t       dy,
  input  pos_t       dz,
  input  view_trig_t vt,
  output logic       out_valid,
  output pos_t       xr,
  output pos_t       yf,
  output pos_t       zf
);

  localparam int PROD_W = POS_W + TRIG_W;
  localparam logic signed [PROD_W:0] HALF_Q14 = (PROD_W+1)'(8192);

  typedef logic signed [PROD_W-1:0] prod_t;

  function automatic pos_t round_q14(input logic signed [PROD_W:0] v);
    logic signed [PROD_W:0] t;
    t = (v + HALF_Q14) >>> 14;
    return POS_W'(t);
  endfunction

  prod_t xc_r, zs_r, xs_r, zc_r;
  prod_t yc_r, rs_r, ys_r, rc_r;
  pos_t dy_a_r, dy_b_r, zr_b_r, xr_b_r, xr_c_r, xr_d_r, yf_d_r, zf_d_r;
  logic va_r, vb_r, vc_r, vd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // yaw products
      xc_r <= PROD_W'(dx) * PROD_W'(vt.cos_yaw);
      zs_r <= PROD_W'(dz) * PROD_W'(vt.sin_yaw);
      xs_r <= PROD_W'(dx) * PROD_W'(vt.sin_yaw);
      zc_r <= PROD_W'(dz) * PROD_W'(vt.cos_yaw);
      dy_a_r <= dy;
      // yaw sums
      xr_b_r <= round_q14((PROD_W+1)'(xc_r) - (PROD_W+1)'(zs_r));
      zr_b_r <= round_q14((PROD_W+1)'(xs_r) + (PROD_W+1)'(zc_r));
      dy_b_r <= dy_a_r;
      // pitch products
      yc_r <= PROD_W'(dy_b_r) * PROD_W'(vt.cos_pitch);
      rs_r <= PROD_W'(zr_b_r) * PROD_W'(vt.sin_pitch);
      ys_r <= PROD_W'(dy_b_r) * PROD_W'(vt.sin_pitch);
      rc_r <= PROD_W'(zr_b_r) * PROD_W'(vt.cos_pitch);
      xr_c_r <= xr_b_r;
      // pitch sums
      yf_d_r <= round_q14((PROD_W+1)'(yc_r) - (PROD_W+1)'(rs_r));
      zf_d_r <= round_q14((PROD_W+1)'(ys_r) + (PROD_W+1)'(rc_r));
      xr_d_r <= xr_c_r;
    end
  end

  assign out_valid = vd_r;
  assign xr = xr_d_r;
  assign yf = yf_d_r;
  assign zf = zf_d_r;

endmodule

>>> src/hvp_div.sv
module hvp_div import hvp_pkg::*; #(
  parameter int CENTER = 10240
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  pos_t                    v,
  input  pos_t                    zf,
  output logic                    out_valid,
  output logic signed [OUT_W-1:0] result,
  output logic                    behind
);

  localparam int D_W = POS_W;
  localparam int N_W = POS_W + 15;
  localparam int RW = N_W + 2;
  localparam logic signed [POS_W:0] VIEW = (POS_W+1)'(VIEW_DIST_Q8);
  localparam logic [N_W-1:0] FOCAL = N_W'(FOCAL_Q4);
  localparam logic signed [RW-1:0] CENTER_Q = RW'(CENTER);
  localparam logic signed [RW-1:0] SAT_HI = RW'(OUT_MAX);
  localparam logic signed [RW-1:0] SAT_LO = RW'(OUT_MIN);

  logic signed [POS_W:0] denom;
  logic [POS_W:0] absv;
  logic pre_behind;

  logic [N_W-1:0] num_nxt [N_W+1], num_r [N_W+1];
  logic [N_W-1:0] quo_nxt [N_W+1], quo_r [N_W+1];
  logic [D_W-1:0] rem_nxt [N_W+1], rem_r [N_W+1];
  logic [D_W-1:0] d_nxt [N_W+1], d_r [N_W+1];
  logic neg_nxt [N_W+1], neg_r [N_W+1];
  logic zero_nxt [N_W+1], zero_r [N_W+1];
  logic bh_nxt [N_W+1], bh_r [N_W+1];
  logic valid_r [N_W+1];
  logic [D_W:0] shifted [N_W];

  logic signed [RW-1:0] offs, sum, sat;
  logic signed [OUT_W-1:0] result_r;
  logic behind_r, out_valid_r;

  always_comb begin
    denom = (POS_W+1)'(zf) + VIEW;
    pre_behind = (denom <= 0);
    absv = (v < 0) ? -((POS_W+1)'(v)) : (POS_W+1)'(v);
    num_nxt[0] = N_W'(absv) * FOCAL + N_W'(denom[POS_W-1:1]);
    d_nxt[0] = pre_behind ? D_W'(1) : denom[D_W-1:0];
    rem_nxt[0] = '0;
    quo_nxt[0] = '0;
    neg_nxt[0] = (v < 0);
    zero_nxt[0] = (v == 0);
    bh_nxt[0] = pre_behind;
    // one quotient bit per stage
    for (int k = 0; k < N_W; k++) begin
      shifted[k] = {rem_r[k], num_r[k][N_W-1]};
      num_nxt[k+1] = {num_r[k][N_W-2:0], 1'b0};
      d_nxt[k+1] = d_r[k];
      neg_nxt[k+1] = neg_r[k];
      zero_nxt[k+1] = zero_r[k];
      bh_nxt[k+1] = bh_r[k];
      if (shifted[k] >= {1'b0, d_r[k]}) begin
        rem_nxt[k+1] = D_W'(shifted[k] - {1'b0, d_r[k]});
        quo_nxt[k+1] = {quo_r[k][N_W-2:0], 1'b1};
      end else begin
        rem_nxt[k+1] = shifted[k][D_W-1:0];
        quo_nxt[k+1] = {quo_r[k][N_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    offs = $signed({2'b00, quo_r[N_W]});
    sum = neg_r[N_W] ? (CENTER_Q - offs) : (CENTER_Q + offs);
    if (bh_r[N_W]) begin
      if (neg_r[N_W]) sum = SAT_LO;
      else if (zero_r[N_W]) sum = CENTER_Q;
      else sum = SAT_HI;
    end
    if (sum > SAT_HI) sat = SAT_HI;
    else if (sum < SAT_LO) sat = SAT_LO;
    else sat = sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= N_W; k++) valid_r[k] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      valid_r[0] <= in_valid;
      for (int k = 0; k < N_W; k++) valid_r[k+1] <= valid_r[k];
      out_valid_r <= valid_r[N_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= N_W; k++) begin
        num_r[k] <= num_nxt[k];
        quo_r[k] <= quo_nxt[k];
        rem_r[k] <= rem_nxt[k];
        d_r[k] <= d_nxt[k];
        neg_r[k] <= neg_nxt[k];
        zero_r[k] <= zero_nxt[k];
        bh_r[k] <= bh_nxt[k];
      end
      result_r <= OUT_W'(sat);
      behind_r <= bh_r[N_W];
    end
  end

  assign out_valid = out_valid_r;
  assign result = result_r;
  assign behind = behind_r;

endmodule

>>> src/hypercube_vertex_projector_unit.sv
// Projects one hypercube vertex index per clock, while in_stall is low, to a saturated
// Q16.4 screen position. The fold sum, the yaw and pitch rotations and the projection
// divide, which retires one quotient bit per pipeline stage, are pipelined in that order.
// The sine and cosine values of every fold angle and of the camera angles are held in
// registers and rebuilt by a single-multiplier polynomial sequencer after reset and after
// every configuration write; in_stall stays high until the rebuild is done. Otherwise an
// item enters every cycle and the whole pipeline holds only while a finished result is
// stalled at the output.
module hypercube_vertex_projector_unit import hvp_pkg::*; #(
  parameter int MAX_DIMENSION = 14,
  parameter int SCREEN_WIDTH = 1280,
  parameter int SCREEN_HEIGHT = 800
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [IDX_W-1:0]        in_vertex_index,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] out_screen_x,
  output logic signed [OUT_W-1:0] out_screen_y,
  output logic                    out_behind_camera,
  input  logic                    cfg_we,
  input  logic [2:0]              cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);

  localparam logic signed [OUT_W-1:0] CENTER_X = OUT_W'(SCREEN_WIDTH * 8);

  logic [3:0] dimension_count_r;
  logic [15:0] fold_phase_r;
  logic signed [15:0] camera_pos_x_r;
  logic signed [15:0] camera_pos_y_r;
  logic signed [15:0] camera_pos_z_r;
  logic [15:0] yaw_phase_r;
  logic [14:0] pitch_phase_r;

  logic [DIM_W-1:0] dims;
  logic en;
  logic trig_busy;
  trig_t cos_tab [MAX_DIMENSION];
  trig_t sin_tab [MAX_DIMENSION];
  view_trig_t view_trig;
  logic fold_valid, rot_valid;
  pos_t dx, dy, dz, xr, yf, zf;
  logic valid_x, valid_y, behind_x, behind_y;
  logic signed [OUT_W-1:0] res_x, res_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dimension_count_r <= 4'd4;
      fold_phase_r <= '0;
      camera_pos_x_r <= '0;
      camera_pos_y_r <= '0;
      camera_pos_z_r <= -16'sd2560;
      yaw_phase_r <= '0;
      pitch_phase_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DIMENSION_COUNT: dimension_count_r <= cfg_data[3:0];
        REG_FOLD_PHASE:      fold_phase_r <= cfg_data;
        REG_CAMERA_POS_X:    camera_pos_x_r <= cfg_data;
        REG_CAMERA_POS_Y:    camera_pos_y_r <= cfg_data;
        REG_CAMERA_POS_Z:    camera_pos_z_r <= cfg_data;
        REG_YAW_PHASE:       yaw_phase_r <= cfg_data;
        REG_PITCH_PHASE:     pitch_phase_r <= cfg_data[14:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (dimension_count_r == '0) dims = DIM_W'(1);
    else if (int'(dimension_count_r) > MAX_DIMENSION) dims = DIM_W'(MAX_DIMENSION);
    else dims = DIM_W'(dimension_count_r);
  end

  assign en = !(out_valid && out_stall);
  assign in_stall = trig_busy || cfg_we || !en;

  hvp_trig #(.MAX_DIMENSION(MAX_DIMENSION)) u_trig (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (cfg_we),
    .fold_phase   (fold_phase_r),
    .yaw_phase    (yaw_phase_r),
    .pitch_phase16({pitch_phase_r[14], pitch_phase_r}),
    .busy         (trig_busy),
    .cos_tab      (cos_tab),
    .sin_tab      (sin_tab),
    .view_trig    (view_trig)
  );

  hvp_fold #(.MAX_DIMENSION(MAX_DIMENSION)) u_fold (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid && !in_stall),
    .in_index (in_vertex_index),
    .dims     (dims),
    .cos_tab  (cos_tab),
    .sin_tab  (sin_tab),
    .cam_x    (camera_pos_x_r),
    .cam_y    (camera_pos_y_r),
    .cam_z    (camera_pos_z_r),
    .out_valid(fold_valid),
    .dx       (dx),
    .dy       (dy),
    .dz       (dz)
  );

  hvp_rotate u_rotate (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (fold_valid),
    .dx       (dx),
    .dy       (dy),
    .dz       (dz),
    .vt       (view_trig),
    .out_valid(rot_valid),
    .xr       (xr),
    .yf       (yf),
    .zf       (zf)
  );

  hvp_div #(.CENTER(SCREEN_WIDTH * 8)) u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (rot_valid),
    .v        (xr),
    .zf       (zf),
    .out_valid(valid_x),
    .result   (res_x),
    .behind   (behind_x)
  );

  hvp_div #(.CENTER(SCREEN_HEIGHT * 8)) u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (rot_valid),
    .v        (yf),
    .zf       (zf),
    .out_valid(valid_y),
    .result   (res_y),
    .behind   (behind_y)
  );

  assign out_valid = valid_x && valid_y;
  assign out_screen_x = res_x;
  assign out_screen_y = res_y;
  assign out_behind_camera = behind_x && behind_y;

`ifndef ASSERT_OFF
  a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> in_stall)
    else $error("input taken right after a configuration write");

  a_axes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_x == valid_y) && (!valid_x || (behind_x == behind_y)))
    else $error("x and y projection lanes out of step");

  a_behind_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_behind_camera) |->
      (out_screen_x == OUT_MAX || out_screen_x == OUT_MIN || out_screen_x == CENTER_X))
    else $error("behind-camera item not saturated");
`endif

endmodule

>>> tb/sv/hypercube_vertex_projector_unit_tb.sv
`timescale 1ns / 1ps

module hypercube_vertex_projector_unit_tb;
  import hvp_pkg::*;

  localparam int MAX_DIMS = 14;
  localparam longint CENTER_X = 1280 * 8;
  localparam longint CENTER_Y = 800 * 8;

  typedef struct {
    logic signed [OUT_W-1:0] sx;
    logic signed [OUT_W-1:0] sy;
    logic                    behind;
  } screen_pt_t;

  class projection_board;
    logic [3:0]         dims;
    logic [15:0]        fold;
    logic signed [15:0] cam_x;
    logic signed [15:0] cam_y;
    logic signed [15:0] cam_z;
    logic [15:0]        yaw;
    logic [14:0]        pitch;
    screen_pt_t         pending[$];
    int                 errors;
    int                 checked;
    int                 behind_seen;

    function new();
      dims = 4;
      fold = 0;
      cam_x = 0;
      cam_y = 0;
      cam_z = -16'sd2560;
      yaw = 0;
      pitch = 0;
      errors = 0;
      checked = 0;
      behind_seen = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] d);
      case (idx)
        REG_DIMENSION_COUNT: dims = d[3:0];
        REG_FOLD_PHASE:      fold = d;
        REG_CAMERA_POS_X:    cam_x = d;
        REG_CAMERA_POS_Y:    cam_y = d;
        REG_CAMERA_POS_Z:    cam_z = d;
        REG_YAW_PHASE:       yaw = d;
        REG_PITCH_PHASE:     pitch = d[14:0];
        default: ;
      endcase
    endfunction

    function longint quarter_wave(longint unsigned q);
      longint unsigned x, x2, p, r;
      x = q << 16;
      x2 = (x * x) >> 30;
      p = 64'(K9);
      p = 64'(K7) - ((p * x2) >> 30);
      p = 64'(K5) - ((p * x2) >> 30);
      p = 64'(K3) - ((p * x2) >> 30);
      p = 64'(K1) - ((p * x2) >> 30);
      r = (((p * x) >> 30) + 32768) >> 16;
      if (r > 16384) r = 16384;
      return longint'(r);
    endfunction

    function longint sin_q14(logic [15:0] ph);
      longint s;
      s = quarter_wave(ph[14] ? 16384 - ph[13:0] : ph[13:0]);
      return ph[15] ? -s : s;
    endfunction

    function longint cos_q14(logic [15:0] ph);
      return sin_q14(ph + 16'h4000);
    endfunction

    function longint rshift_round(longint v, int sh);
      return (v + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function longint to_screen(longint v, longint denom, longint center);
      longint mag, off, r;
      mag = (v < 0 ? -v : v) * FOCAL_Q4;
      off = (mag + denom / 2) / denom;
      r = center + (v < 0 ? -off : off);
      if (r > 524287) r = 524287;
      if (r < -524288) r = -524288;
      return r;
    endfunction

    function screen_pt_t project_vertex(logic [13:0] vidx);
      screen_pt_t pt;
      int n;
      longint ax, ay, az, c, s, dx, dy, dz, xr, zr, yf, zf, denom, cy, sy, cp, sp;
      logic [63:0] t;
      logic [15:0] ph, p16;
      n = int'(dims);
      if (n < 1) n = 1;
      if (n > MAX_DIMS) n = MAX_DIMS;
      ax = 0;
      ay = 0;
      az = 0;
      for (int i = 0; i < n; i++) begin
        t = 64'(i) * 64'd341782637 + 64'd32768;
        ph = fold + t[31:16];
        c = cos_q14(ph);
        s = sin_q14(ph);
        if (vidx[i]) begin
          ax += c;
          ay += s;
          az += (i % 2 == 0) ? c : s;
        end else begin
          ax -= c;
          ay -= s;
          az -= (i % 2 == 0) ? c : s;
        end
      end
      dx = rshift_round(ax, 6) - longint'(cam_x);
      dy = rshift_round(ay, 6) - longint'(cam_y);
      dz = rshift_round(az, 6) - longint'(cam_z);
      cy = cos_q14(yaw);
      sy = sin_q14(yaw);
      xr = rshift_round(dx * cy - dz * sy, 14);
      zr = rshift_round(dx * sy + dz * cy, 14);
      p16 = {pitch[14], pitch};
      cp = cos_q14(p16);
      sp = sin_q14(p16);
      yf = rshift_round(dy * cp - zr * sp, 14);
      zf = rshift_round(dy * sp + zr * cp, 14);
      denom = zf + VIEW_DIST_Q8;
      if (denom <= 0) begin
        pt.sx = xr > 0 ? OUT_MAX : (xr < 0 ? OUT_MIN : OUT_W'(CENTER_X));
        pt.sy = yf > 0 ? OUT_MAX : (yf < 0 ? OUT_MIN : OUT_W'(CENTER_Y));
        pt.behind = 1'b1;
      end else begin
        pt.sx = OUT_W'(to_screen(xr, denom, CENTER_X));
        pt.sy = OUT_W'(to_screen(yf, denom, CENTER_Y));
        pt.behind = 1'b0;
      end
      return pt;
    endfunction

    function void note_vertex(logic [13:0] vidx);
      pending.insert(pending.size(), project_vertex(vidx));
    endfunction

    function void check_point(logic signed [OUT_W-1:0] sx, logic signed [OUT_W-1:0] sy,
                              logic behind);
      screen_pt_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected item x=%0d y=%0d behind=%0b", $time, sx, sy, behind);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (behind) behind_seen++;
      if (sx !== e.sx) begin
        $display("%0t: screen_x expected %0d actual %0d", $time, e.sx, sx);
        errors++;
      end
      if (sy !== e.sy) begin
        $display("%0t: screen_y expected %0d actual %0d", $time, e.sy, sy);
        errors++;
      end
      if (behind !== e.behind) begin
        $display("%0t: behind_camera expected %0b actual %0b", $time, e.behind, behind);
        errors++;
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [IDX_W-1:0]        in_vertex_index;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [OUT_W-1:0] out_screen_x;
  logic signed [OUT_W-1:0] out_screen_y;
  logic                    out_behind_camera;
  logic                    cfg_we;
  logic [2:0]              cfg_index;
  logic [CFG_W-1:0]        cfg_data;

  projection_board board;
  logic [13:0] corner_idx [7];
  int send_idle_pct;
  int recv_idle_pct;
  int hold_requests;
  int hold_seen;
  int hold_left;
  int sent;
  int cfg_writes;

  hypercube_vertex_projector_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_vertex_index(in_vertex_index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_screen_x(out_screen_x),
    .out_screen_y(out_screen_y),
    .out_behind_camera(out_behind_camera),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("end of test: mismatches");
    $finish;
  end

  // receiver side: random stall plus long hold-offs on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_seen <= 0;
      hold_left <= 0;
    end else if (hold_requests != hold_seen) begin
      hold_seen <= hold_requests;
      hold_left <= 300;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) board.note_vertex(in_vertex_index);
    if (rst_n && out_valid && !out_stall)
      board.check_point(out_screen_x, out_screen_y, out_behind_camera);
  end

  task automatic write_reg(logic [2:0] idx, logic [15:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    board.set_reg(idx, d);
    cfg_writes++;
  endtask

  task automatic write_all(logic [3:0] dc, logic [15:0] fp, logic [15:0] cx,
                           logic [15:0] cy, logic [15:0] cz, logic [15:0] yw,
                           logic [14:0] pt);
    write_reg(REG_DIMENSION_COUNT, {12'd0, dc});
    write_reg(REG_FOLD_PHASE, fp);
    write_reg(REG_CAMERA_POS_X, cx);
    write_reg(REG_CAMERA_POS_Y, cy);
    write_reg(REG_CAMERA_POS_Z, cz);
    write_reg(REG_YAW_PHASE, yw);
    write_reg(REG_PITCH_PHASE, {1'b0, pt});
    cfg_we <= 1'b0;
  endtask

  task automatic send_vertex(logic [13:0] vidx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_vertex_index <= vidx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic random_config();
    logic [15:0] cx, cy, cz;
    if ($urandom_range(3) == 0) begin
      cx = 16'($urandom);
      cy = 16'($urandom);
      cz = 16'($urandom);
    end else begin
      cx = 16'($signed($urandom_range(2048)) - 1024);
      cy = 16'($signed($urandom_range(2048)) - 1024);
      cz = 16'($signed($urandom_range(4096)) - 3584);
    end
    write_all(4'($urandom_range(15)), 16'($urandom), cx, cy, cz, 16'($urandom),
              15'($urandom));
  endtask

  initial begin
    board = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_vertex_index = '0;
    cfg_we = 1'b0;
    cfg_index = REG_DIMENSION_COUNT;
    cfg_data = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests = 0;
    sent = 0;
    cfg_writes = 0;
    corner_idx = '{14'd0, 14'h3FFF, 14'h2AAA, 14'h1555, 14'd1, 14'h2000, 14'hF};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, field extremes
    foreach (corner_idx[k])
      send_vertex(corner_idx[k]);
    drain();
    // zero dimension count, camera x on vertex 1 so its rotated x is zero, behind camera
    write_all(4'd0, 16'd0, 16'd256, 16'd0, 16'd2560, 16'd0, 15'd0);
    send_vertex(14'd1);
    send_vertex(14'd0);
    send_vertex(14'h3FFE);
    drain();
    // count above the limit, all extremes
    write_all(4'd15, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h8000, 16'hFFFF, 15'h3FFF);
    send_vertex(14'h3FFF);
    send_vertex(14'd0);
    send_vertex(14'h2AAA);
    drain();
    write_all(4'd14, 16'd0, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h0000, 15'h4000);
    send_vertex(14'h3FFF);
    send_vertex(14'h1555);
    drain();
    write_all(4'd1, 16'h4000, 16'd0, 16'd0, 16'hF600, 16'h8000, 15'h7FFF);
    send_vertex(14'd0);
    send_vertex(14'd1);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      if (ph < 3) begin
        send_idle_pct = 23;
        recv_idle_pct = 86;
      end else if (ph < 6) begin
        send_idle_pct = 86;
        recv_idle_pct = 23;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (ph == 0)
        write_all(4'd4, 16'd0, 16'd0, 16'd0, 16'hF600, 16'd0, 15'd0);
      else
        random_config();
      for (int n = 0; n < 50; n++) begin
        if ((ph == 1 || ph == 7) && n == 5) hold_requests++;
        send_vertex(14'($urandom_range(16383)));
      end
      drain();
    end

    $display("%0d vertices checked over %0d register writes, %0d behind the camera",
             board.checked, cfg_writes, board.behind_seen);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
